// ===== rtl/skvb_pkg.sv =====
// shared constants, codes and request/result types for the sorted key/value buffer
// no dependencies
`timescale 1ns / 1ps

package skvb_pkg;

  localparam int CAPACITY    = 32;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // command codes, code three is reserved and acts as find
  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_UPDATED = 2'd1;
  localparam logic [1:0] STAT_ABSENT  = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [KEY_WIDTH-1:0]   req_key;
    logic [VALUE_WIDTH-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [VALUE_WIDTH-1:0] found_value;
    logic [CNT_W-1:0]       entry_total;
  } rsp_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                   lt;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } link_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic compare_en;
    logic ins;
    logic ers;
    logic upd;
  } cell_ctrl_t;

endpackage

// ===== rtl/skvb_cell.sv =====
// one storage cell of the sorted key/value buffer: holds a pair and its compare flags
// depends on skvb_pkg
`timescale 1ns / 1ps

module skvb_cell (
  input  logic                            clk,
  input  skvb_pkg::cell_ctrl_t            ctrl,
  input  logic                            occupied,
  input  logic [skvb_pkg::KEY_WIDTH-1:0]  cmp_key,
  input  logic [skvb_pkg::KEY_WIDTH-1:0]  new_key,
  input  logic [skvb_pkg::VALUE_WIDTH-1:0] new_value,
  input  skvb_pkg::link_t                 left,
  input  skvb_pkg::link_t                 right,
  output skvb_pkg::link_t                 link,
  output logic                            eq
);
  import skvb_pkg::*;

  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;
  logic                   lt;

  assign link.lt    = lt;
  assign link.key   = key;
  assign link.value = value;

  // flags are taken when the request is accepted
  always_ff @(posedge clk) begin
    if (ctrl.compare_en) begin
      lt <= occupied && (key < cmp_key);
      eq <= occupied && (key == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && eq) begin
      value <= new_value;
    end else if (ctrl.ins && !lt) begin
      if (left.lt) begin
        key   <= new_key;
        value <= new_value;
      end else begin
        key   <= left.key;
        value <= left.value;
      end
    end else if (ctrl.ers && !lt) begin
      key   <= right.key;
      value <= right.value;
    end
  end

endmodule

// ===== rtl/sorted_key_value_buffer.sv =====
// top level of the sorted key/value buffer: sequencer, count and a row of skvb_cell
// depends on skvb_pkg and skvb_cell
`timescale 1ns / 1ps

// sorted key/value buffer
//
// holds up to CAPACITY key/value pairs in ascending key order in a row of
// cells, cell i holding the i-th smallest key, plus an entry count.
// request channel: req (cmd, req_key, req_value) is taken at a rising edge
// where start is high and busy is low. cmd is find, insert/update or erase;
// the reserved code acts as find.
// result channel: rsp (status, found_value, entry_total) is shown for
// exactly one cycle with done high; the receiver cannot hold it off.
// timing: at the accept edge every cell compares its key with req_key and
// keeps less-than and equal flags. at the next edge every cell acts at once:
// insert loads the new pair at its sorted slot and shifts later cells up by
// one, erase pulls later cells down by one, update rewrites the matching
// value. done is high in the cycle after that edge. a new request is not
// accepted while busy, so one request is through the cell row before the
// next is taken. start may be high in the cycle where done is high.
// reset clears the sequencer and the entry count; cell contents are left
// as they are and are read only once written.
module sorted_key_value_buffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  skvb_pkg::req_t req,
  output logic           done,
  output skvb_pkg::rsp_t rsp
);
  import skvb_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic             state;
  logic             accept;
  req_t             req_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  link_t                   links [CAPACITY];
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     lt_vec;
  cell_ctrl_t              ctrl;

  logic                   hit;
  logic                   full;
  logic [1:0]             status_next;
  logic [VALUE_WIDTH-1:0] match_value;

  assign busy   = (state == S_APPLY);
  assign accept = start && !busy;

  // request register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_APPLY;
        S_APPLY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // decision from the flags the cells took at accept
  assign hit  = |eq_vec;
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    ctrl            = '0;
    ctrl.compare_en = accept;
    count_next      = count;
    status_next     = STAT_DONE;
    case (req_q.cmd)
      CMD_INSERT: begin
        if (hit) begin
          ctrl.upd    = busy;
          status_next = STAT_UPDATED;
        end else if (full) begin
          status_next = STAT_FULL;
        end else begin
          ctrl.ins   = busy;
          count_next = count + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          ctrl.ers   = busy;
          count_next = count - 1'b1;
        end else begin
          status_next = STAT_ABSENT;
        end
      end
      default: begin
        if (!hit) status_next = STAT_ABSENT;
      end
    endcase
  end

  // at most one cell matches, so an or over masked values picks it
  always_comb begin
    match_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_vec[i]) match_value = match_value | links[i].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy;
      if (busy) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rsp.status      <= status_next;
      rsp.entry_total <= count_next;
      // find and the reserved code report the value, everything else zero
      rsp.found_value <= ((req_q.cmd != CMD_INSERT) && (req_q.cmd != CMD_ERASE))
                         ? match_value : '0;
    end
  end

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_link;
    link_t right_link;

    if (i == 0) begin : g_first
      // the slot before cell zero counts as below every key
      assign left_link = '{lt: 1'b1, key: '0, value: '0};
    end else begin : g_mid
      assign left_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_link = '0;
    end else begin : g_inner
      assign right_link = links[i+1];
    end

    skvb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < count),
      .cmp_key   (req.req_key),
      .new_key   (req_q.req_key),
      .new_value (req_q.req_value),
      .left      (left_link),
      .right     (right_link),
      .link      (links[i]),
      .eq        (eq_vec[i])
    );

    assign lt_vec[i] = links[i].lt;
  end

  // stored count never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // keys are unique, so no two cells match one key
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(eq_vec))
    else $error("more than one cell matched");

  // sorted order: less-than flags form a run from cell zero
  a_lt_prefix: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
    else $error("cell order broken");

  // a result follows each apply cycle and nothing else
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without request");

  // a full rejection only happens at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STAT_FULL)) |-> (rsp.entry_total == CNT_W'(CAPACITY)))
    else $error("full status below capacity");

endmodule

// ===== test/skvb_checker.sv =====
// request/result checker for the sorted key/value buffer: predicts each result and compares it
// depends on skvb_pkg
`timescale 1ns / 1ps

module skvb_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  skvb_pkg::req_t req,
  input  logic           done,
  input  skvb_pkg::rsp_t rsp,
  output int             pending,
  output int             mismatches
);
  import skvb_pkg::*;

  // predicted contents, sorted ascending, only entries below pair_count are valid
  logic [KEY_WIDTH-1:0]   key_row   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_row [CAPACITY];
  int                     pair_count = 0;

  rsp_t owed_rsp [$];
  rsp_t want;
  int   miss_count = 0;
  int   result_seq = 0;
  int   owed_total = 0;

  assign mismatches = miss_count;
  assign pending    = owed_total;

  task automatic note_mismatch(string what);
    $display("%0t ns: result %0d: %s", $time, result_seq, what);
    miss_count++;
  endtask

  // applies one request to the predicted contents and returns its result
  function automatic rsp_t run_buffer_op(req_t r);
    rsp_t res;
    int   pos;
    bit   hit;
    res = '0;
    res.status = STAT_DONE;
    pos = 0;
    while (pos < pair_count && key_row[pos] < r.req_key) pos++;
    hit = (pos < pair_count) && (key_row[pos] == r.req_key);
    case (r.cmd)
      CMD_INSERT: begin
        if (hit) begin
          value_row[pos] = r.req_value;
          res.status = STAT_UPDATED;
        end else if (pair_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = pair_count; i > pos; i--) begin
            key_row[i]   = key_row[i-1];
            value_row[i] = value_row[i-1];
          end
          key_row[pos]   = r.req_key;
          value_row[pos] = r.req_value;
          pair_count++;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          for (int i = pos; i + 1 < pair_count; i++) begin
            key_row[i]   = key_row[i+1];
            value_row[i] = value_row[i+1];
          end
          pair_count--;
        end else begin
          res.status = STAT_ABSENT;
        end
      end
      default: begin
        // find, and the reserved code that acts as find
        if (hit) res.found_value = value_row[pos];
        else res.status = STAT_ABSENT;
      end
    endcase
    res.entry_total = CNT_W'(pair_count);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      owed_rsp.delete();
      pair_count = 0;
    end else begin
      // results first: nothing accepted at this edge can already be answered
      if (done) begin
        if (owed_rsp.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.found_value !== want.found_value)
            note_mismatch($sformatf("found_value got %h want %h",
                                    rsp.found_value, want.found_value));
          if (rsp.entry_total !== want.entry_total)
            note_mismatch($sformatf("entry_total got %0d want %0d",
                                    rsp.entry_total, want.entry_total));
        end
        result_seq++;
      end
      if (start && !busy) owed_rsp.push_back(run_buffer_op(req));
    end
    owed_total <= owed_rsp.size();
  end

endmodule

// ===== test/tb_sorted_key_value_buffer.sv =====
// testbench top for the sorted key/value buffer: clock, reset, request stimulus and verdict
// depends on skvb_pkg, sorted_key_value_buffer and skvb_checker
`timescale 1ns / 1ps

module tb_sorted_key_value_buffer;
  import skvb_pkg::*;

  // reserved command code, the block treats it as find
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam int RANDOM_ITEMS  = 1380;
  localparam int PHASE_LEN     = 150;  // requests per traffic mix
  localparam int KEY_POOL_SIZE = 40;   // more than CAPACITY so the buffer can overflow
  localparam int MAX_GAP       = 8;
  localparam int MAX_BURST     = 40;
  localparam int SETTLE_CYCLES = 8;    // margin after the last result

  // traffic mixes: fill pushes toward full, drain toward empty
  typedef enum logic [1:0] {MIX_FILL, MIX_EVEN, MIX_DRAIN} op_mix_e;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  int   pending;
  int   mismatch_total;

  // keys that come back often, so that finds, updates and erases hit
  logic [KEY_WIDTH-1:0] key_pool [KEY_POOL_SIZE];

  int      burst_left;
  int      gap;
  op_mix_e mix;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_key_value_buffer DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  skvb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .pending    (pending),
    .mismatches (mismatch_total)
  );

  function automatic req_t make_req(logic [1:0] cmd, logic [KEY_WIDTH-1:0] key,
                                    logic [VALUE_WIDTH-1:0] value);
    req_t r;
    r.cmd       = cmd;
    r.req_key   = key;
    r.req_value = value;
    return r;
  endfunction

  // one random request under the given traffic mix
  function automatic req_t draw_request(op_mix_e m);
    int                     roll;
    int                     ins_pct;
    int                     ers_pct;
    logic [1:0]             cmd;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    case (m)
      MIX_FILL: begin
        ins_pct = 70;
        ers_pct = 10;
      end
      MIX_DRAIN: begin
        ins_pct = 15;
        ers_pct = 60;
      end
      default: begin
        ins_pct = 40;
        ers_pct = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) cmd = CMD_INSERT;
    else if (roll < ins_pct + ers_pct) cmd = CMD_ERASE;
    else if (roll < 97) cmd = CMD_FIND;
    else cmd = CMD_RSVD;
    // mostly pool keys, the rest anywhere in the key range
    if ($urandom_range(0, 3) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    return make_req(cmd, key, value);
  endfunction

  // holds start high until the request is taken; start stays high afterward
  // so the next request can follow back to back
  task automatic issue(req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;

    // pool holds the key extremes, the sign-bit boundary and random keys
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h7fff_ffff;
    for (int i = 5; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty buffer, ends of the key range, update, hits and misses
    issue(make_req(CMD_FIND,   32'h0000_0000, 32'h0000_0000)); // find on empty
    issue(make_req(CMD_ERASE,  32'h0000_0005, 32'h0000_0000)); // erase on empty
    issue(make_req(CMD_INSERT, 32'h0000_0000, 32'hffff_ffff)); // smallest key
    issue(make_req(CMD_INSERT, 32'hffff_ffff, 32'h0000_0000)); // largest key
    issue(make_req(CMD_INSERT, 32'h8000_0000, 32'ha5a5_a5a5)); // unsigned ordering
    issue(make_req(CMD_INSERT, 32'h7fff_ffff, 32'h5a5a_5a5a)); // lands in the middle
    issue(make_req(CMD_INSERT, 32'h0000_0001, 32'h0000_0001)); // right after the first
    issue(make_req(CMD_INSERT, 32'h0000_0000, 32'h1234_5678)); // existing key, update
    issue(make_req(CMD_FIND,   32'h0000_0000, 32'h0000_0000)); // sees the update
    issue(make_req(CMD_FIND,   32'hffff_ffff, 32'hffff_ffff)); // hit with zero value
    issue(make_req(CMD_FIND,   32'h0000_0002, 32'h0000_0000)); // miss between keys
    issue(make_req(CMD_RSVD,   32'h8000_0000, 32'h0000_0000)); // reserved acts as find
    issue(make_req(CMD_RSVD,   32'h0000_0003, 32'hffff_ffff)); // reserved, miss
    issue(make_req(CMD_ERASE,  32'h7fff_ffff, 32'h0000_0000)); // erase in the middle
    issue(make_req(CMD_ERASE,  32'h7fff_ffff, 32'h0000_0000)); // same key again, miss
    issue(make_req(CMD_ERASE,  32'hffff_ffff, 32'h0000_0000)); // erase the last entry
    issue(make_req(CMD_ERASE,  32'h0000_0000, 32'h0000_0000)); // erase the first entry
    issue(make_req(CMD_ERASE,  32'h0000_0001, 32'hffff_ffff)); // value ignored on erase
    issue(make_req(CMD_FIND,   32'h8000_0000, 32'hffff_ffff)); // value ignored on find
    issue(make_req(CMD_ERASE,  32'h8000_0000, 32'h0000_0000)); // back to empty
    issue(make_req(CMD_ERASE,  32'h8000_0000, 32'h0000_0000)); // erase on empty again

    // random: mixes rotate fill, even, drain so the buffer runs full
    // (updates and rejected inserts) and back down toward empty
    burst_left = $urandom_range(1, MAX_BURST);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mix = op_mix_e'((n / PHASE_LEN) % 3);
      issue(draw_request(mix));
      burst_left--;
      if (burst_left == 0) begin
        // gap after the burst, zero now and then so bursts run together
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, MAX_BURST);
      end
    end
    start <= 1'b0;

    // wait for every outstanding result, then let the pipeline settle
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: a clean run takes well under a tenth of this
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sorted_key_value_buffer.f =====
rtl/skvb_pkg.sv
rtl/skvb_cell.sv
rtl/sorted_key_value_buffer.sv
test/skvb_checker.sv
test/tb_sorted_key_value_buffer.sv
